@@ rtl/ers_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ers_pkg
// Shared types, field widths and codes for the emitter ring scheduler.
// ----------------------------------------------------------------------------
package ers_pkg;

  localparam int SLOTS_DEF      = 64;
  localparam int MAX_CHUNKS_DEF = 16;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;

  localparam int LIVE_W   = 7;
  localparam int SLOT_W   = 6;
  localparam int BIRTHS_W = 11;
  localparam int EXP_W    = 7;
  localparam int TIME_W   = 32;
  localparam int STEP_W   = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BURST_SIZE      = 3'd0,
    CFG_SLOTS_IN_USE    = 3'd1,
    CFG_EMIT_DELAY      = 3'd2,
    CFG_ACTIVE_DURATION = 3'd3,
    CFG_SLOT_LIFETIME   = 3'd4,
    CFG_REVERSE_ORDER   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [6:0]        burst_size;
    logic [6:0]        slots_in_use;
    logic [STEP_W-1:0] emit_delay;
    logic [TIME_W-1:0] active_duration;
    logic [TIME_W-1:0] slot_lifetime;
    logic              reverse_order;
  } cfg_t;

  typedef struct packed {
    logic              mode;
    logic [STEP_W-1:0] frame_step;
  } in_item_t;

  typedef struct packed {
    logic [LIVE_W-1:0]   live_count;
    logic [SLOT_W-1:0]   head_slot;
    logic [SLOT_W-1:0]   tail_slot;
    logic [BIRTHS_W-1:0] births;
    logic [EXP_W-1:0]    expired;
    logic                chunk_limit_hit;
    logic [TIME_W-1:0]   current_time;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_BURST,
    ST_CHUNK,
    ST_POP_RD,
    ST_POP_CHK,
    ST_DONE
  } state_t;

  // unsigned add, saturating at all ones
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/ers_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ers_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ers_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire                      re,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/ers_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ers_cfg
// Configuration register file, written by index.
// ----------------------------------------------------------------------------
module ers_cfg
  import ers_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cfg_we,
  input  wire  [CFG_INDEX_W-1:0] cfg_index,
  input  wire  [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.burst_size      <= 7'd1;
      cfg.slots_in_use    <= 7'd64;
      cfg.emit_delay      <= 16'd256;
      cfg.active_duration <= '0;
      cfg.slot_lifetime   <= 32'd7680;
      cfg.reverse_order   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_BURST_SIZE:      cfg.burst_size      <= cfg_data[6:0];
        CFG_SLOTS_IN_USE:    cfg.slots_in_use    <= cfg_data[6:0];
        CFG_EMIT_DELAY:      cfg.emit_delay      <= cfg_data[STEP_W-1:0];
        CFG_ACTIVE_DURATION: cfg.active_duration <= cfg_data[TIME_W-1:0];
        CFG_SLOT_LIFETIME:   cfg.slot_lifetime   <= cfg_data[TIME_W-1:0];
        CFG_REVERSE_ORDER:   cfg.reverse_order   <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/ers_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ers_ctrl
// Sequencer for one tick: store clear on restart, chunk walk, burst writes
// into the birth-time store and expiry pops from the head.
// ----------------------------------------------------------------------------
module ers_ctrl
  import ers_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
  input  wire        clk,
  input  wire        rst,
  input  wire cfg_t  cfg,
  input  wire        start,
  input  wire in_item_t item,
  output logic       busy,
  output logic       res_valid,
  input  wire        res_take,
  output out_item_t  res
);

  localparam int IW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  localparam int CW = $clog2(MAX_CHUNKS + 1);

  state_t state, state_next;

  logic [TIME_W-1:0] emit_time, next_emit;
  logic [IW-1:0]     head, tail, clr;
  logic [LW-1:0]     live, k;
  logic [STEP_W-1:0] rem;
  logic [CW-1:0]     chunks;
  logic [BIRTHS_W-1:0] births;
  logic [EXP_W-1:0]  expired;
  logic              restart;

  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_waddr;
  logic [TIME_W-1:0] ram_wdata, ram_rdata;

  logic [LW-1:0]     len, n;
  logic [STEP_W-1:0] frames, rem_new;
  logic [TIME_W-1:0] t_new;
  logic [CW-1:0]     chunks_new;
  logic              emit_cond, more_new, more_reg, burst_last, n_zero;
  logic [LW:0]       live_inc;
  logic              overflow, pop_keep, clr_last;

  function automatic logic [IW-1:0] move_idx(input logic [IW-1:0] idx,
                                             input logic [LW-1:0] ln,
                                             input logic rev);
    logic [LW:0] inc;
    inc = (LW+1)'(idx) + (LW+1)'(1);
    if (rev) begin
      return (idx == '0) ? IW'(ln - LW'(1)) : idx - IW'(1);
    end
    return (inc >= (LW+1)'(ln)) ? '0 : IW'(inc);
  endfunction

  ers_ram #(
    .WIDTH (TIME_W),
    .DEPTH (SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head),
    .rdata (ram_rdata)
  );

  // shared datapath terms
  always_comb begin
    if (cfg.slots_in_use == '0) begin
      len = LW'(1);
    end else if (32'(cfg.slots_in_use) > SLOTS) begin
      len = LW'(SLOTS);
    end else begin
      len = LW'(cfg.slots_in_use);
    end
    n = (32'(cfg.burst_size) > SLOTS) ? LW'(SLOTS) : LW'(cfg.burst_size);
    n_zero = (n == '0);

    frames = (cfg.emit_delay == '0 || rem <= cfg.emit_delay) ? rem : cfg.emit_delay;
    t_new = sat_add(emit_time, TIME_W'(frames));
    emit_cond = (cfg.active_duration == '0 || t_new < cfg.active_duration)
                && (t_new >= next_emit);
    rem_new = rem - frames;
    chunks_new = chunks + CW'(1);
    more_new = (rem_new != '0) && (chunks_new < CW'(MAX_CHUNKS));
    more_reg = (rem != '0) && (chunks < CW'(MAX_CHUNKS));

    burst_last = ((LW+1)'(k) + (LW+1)'(1)) == (LW+1)'(n);
    live_inc = (LW+1)'(live) + (LW+1)'(1);
    overflow = live_inc > (LW+1)'(len);
    pop_keep = ({1'b0, ram_rdata} + {1'b0, cfg.slot_lifetime}) > {1'b0, emit_time};
    clr_last = (clr == IW'(SLOTS - 1));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (start) state_next = item.mode ? ST_CLEAR : ST_CHUNK;
      ST_CLEAR:   if (clr_last) state_next = n_zero ? ST_CHUNK : ST_BURST;
      ST_BURST: begin
        if (burst_last) begin
          state_next = (restart || more_reg) ? ST_CHUNK : ST_POP_RD;
        end
      end
      ST_CHUNK: begin
        if (emit_cond && !n_zero) begin
          state_next = ST_BURST;
        end else begin
          state_next = more_new ? ST_CHUNK : ST_POP_RD;
        end
      end
      ST_POP_RD:  state_next = (live == '0) ? ST_DONE : ST_POP_CHK;
      ST_POP_CHK: state_next = pop_keep ? ST_DONE : ST_POP_RD;
      ST_DONE:    if (res_take) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy      = (state != ST_IDLE);
    res_valid = (state == ST_DONE);
    ram_we    = (state == ST_CLEAR) || (state == ST_BURST);
    ram_waddr = (state == ST_CLEAR) ? clr : tail;
    ram_wdata = (state == ST_CLEAR) ? '0 : next_emit;
    ram_re    = (state == ST_POP_RD);

    res.live_count      = LIVE_W'(live);
    res.head_slot       = SLOT_W'(head);
    res.tail_slot       = SLOT_W'(tail);
    res.births          = births;
    res.expired         = expired;
    res.chunk_limit_hit = (rem != '0);
    res.current_time    = emit_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      emit_time <= '0;
      next_emit <= '0;
      head      <= '0;
      tail      <= '0;
      live      <= '0;
      clr       <= '0;
      k         <= '0;
      rem       <= '0;
      chunks    <= '0;
      births    <= '0;
      expired   <= '0;
      restart   <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            rem     <= item.frame_step;
            chunks  <= '0;
            births  <= '0;
            expired <= '0;
            k       <= '0;
            clr     <= '0;
            restart <= item.mode;
            if (item.mode) begin
              emit_time <= '0;
              next_emit <= '0;
              head      <= '0;
              tail      <= '0;
              live      <= '0;
            end
          end
        end
        ST_CLEAR: begin
          clr <= clr + IW'(1);
          if (clr_last && n_zero) begin
            next_emit <= TIME_W'(cfg.emit_delay);
            restart   <= 1'b0;
          end
        end
        ST_BURST: begin
          // one slot a cycle; a full ring drops its oldest slot
          tail   <= move_idx(tail, len, cfg.reverse_order);
          births <= births + BIRTHS_W'(1);
          if (overflow) begin
            head <= move_idx(head, len, cfg.reverse_order);
          end else begin
            live <= LW'(live_inc);
          end
          if (burst_last) begin
            k       <= '0;
            restart <= 1'b0;
            next_emit <= restart ? TIME_W'(cfg.emit_delay)
                                 : sat_add(next_emit, TIME_W'(cfg.emit_delay));
          end else begin
            k <= k + LW'(1);
          end
        end
        ST_CHUNK: begin
          emit_time <= t_new;
          rem       <= rem_new;
          chunks    <= chunks_new;
          if (emit_cond && n_zero) begin
            next_emit <= sat_add(next_emit, TIME_W'(cfg.emit_delay));
          end
        end
        ST_POP_CHK: begin
          if (!pop_keep) begin
            head    <= move_idx(head, len, cfg.reverse_order);
            live    <= live - LW'(1);
            expired <= expired + EXP_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/emitter_ring_scheduler.sv @@
`default_nettype none
// Sequence: a restart clears the birth-time store and writes a first burst; the
//   chunk walk follows, with burst writes where an emission falls due, then head pops.
// Throughput: one item at a time; store clearing and burst writes use the write port
//   of the birth-time store, and head pops use its read port.
// Reset: synchronous, active high; clears time, ring pointers, live count and
//   configuration to defaults; the birth-time store is not cleared by reset.
// ----------------------------------------------------------------------------
// emitter_ring_scheduler
// Slot ring scheduler for one emitter, with output register.
// ----------------------------------------------------------------------------
module emitter_ring_scheduler
  import ers_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire                    out_stall,
  output out_item_t              out_data,
  input  wire                    cfg_we,
  input  wire  [CFG_INDEX_W-1:0] cfg_index,
  input  wire  [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t      cfg;
  logic      busy, res_valid, take, accept;
  out_item_t res;

  ers_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ers_ctrl #(
    .SLOTS      (SLOTS),
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (accept),
    .item      (in_data),
    .busy      (busy),
    .res_valid (res_valid),
    .res_take  (take),
    .res       (res)
  );

  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  // result moves to the output register once it is empty or its transfer completes
  assign take     = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= res;
    end
  end

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("accepted item did not hold off the input");

  a_take_loads: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("taken result not presented");

  a_res_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !take) |=> res_valid)
    else $error("finished result dropped before transfer");

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.live_count <= SLOTS))
    else $error("live count beyond ring size");
`endif

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the emitter ring scheduler. A queue-fed driver
// offers ticks and restarts, a clocked predictor works out the ring status
// for every accepted transfer, and the monitor compares each returned status
// field by field in order. Register settings change between phases, and
// idling on both sides is varied phase by phase.
// ----------------------------------------------------------------------------
module tb_top;
  import ers_pkg::*;

  localparam int SLOTS      = SLOTS_DEF;
  localparam int MAX_CHUNKS = MAX_CHUNKS_DEF;

  typedef struct {
    in_item_t item;
    bit       wait_drain;   // hold back until every status has returned
  } tick_req_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_item_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  emitter_ring_scheduler #(
    .SLOTS      (SLOTS),
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  tick_req_t tick_q[$];
  out_item_t ring_status_q[$];
  tick_req_t tx_next;
  int        mismatches  = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  int        hold_asked  = 0;
  int        hold_taken  = 0;
  int        hold_left   = 0;

  // predictor state
  cfg_t        model_cfg;
  logic [31:0] em_time;
  logic [31:0] next_emit;
  logic [5:0]  ring_head;
  logic [5:0]  ring_tail;
  logic [6:0]  ring_live;
  logic [31:0] birth_mem [0:SLOTS-1];

  function automatic int ring_length();
    if (model_cfg.slots_in_use == 0) return 1;
    if (model_cfg.slots_in_use > SLOTS) return SLOTS;
    return int'(model_cfg.slots_in_use);
  endfunction

  function automatic logic [5:0] next_slot(input logic [5:0] idx, input int len);
    int top;
    top = len - 1;
    if (model_cfg.reverse_order) return (idx == 0) ? top[5:0] : idx - 6'd1;
    return (int'(idx) + 1 >= len) ? 6'd0 : idx + 6'd1;
  endfunction

  function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
    if (a > 32'hFFFF_FFFF - b) return 32'hFFFF_FFFF;
    return a + b;
  endfunction

  // one burst at the tail; a full ring drops its oldest slot
  function automatic int write_burst();
    int len;
    int n;
    int k;
    len = ring_length();
    n = (model_cfg.burst_size > SLOTS) ? SLOTS : int'(model_cfg.burst_size);
    for (k = 0; k < n; k++) begin
      birth_mem[ring_tail] = next_emit;
      ring_tail = next_slot(ring_tail, len);
      ring_live = ring_live + 7'd1;
      if (ring_live > len) begin
        ring_head = next_slot(ring_head, len);
        ring_live = ring_live - 7'd1;
      end
    end
    return n;
  endfunction

  function automatic out_item_t predict_tick(input in_item_t it);
    out_item_t   st;
    logic [15:0] rem;
    logic [15:0] frames;
    logic [32:0] expiry;
    int          births;
    int          chunks;
    int          popped;
    int          len;
    int          k;
    bit          done;
    births = 0;
    chunks = 0;
    popped = 0;
    if (it.mode) begin
      for (k = 0; k < SLOTS; k++) birth_mem[k] = '0;
      em_time   = '0;
      next_emit = '0;
      ring_head = '0;
      ring_tail = '0;
      ring_live = '0;
      births += write_burst();
      next_emit = {16'd0, model_cfg.emit_delay};
    end
    rem = it.frame_step;
    do begin
      frames = (model_cfg.emit_delay == 0 || rem <= model_cfg.emit_delay) ?
               rem : model_cfg.emit_delay;
      em_time = sat_sum(em_time, {16'd0, frames});
      if (model_cfg.active_duration == 0 || em_time < model_cfg.active_duration) begin
        if (em_time >= next_emit) begin
          births += write_burst();
          next_emit = sat_sum(next_emit, {16'd0, model_cfg.emit_delay});
        end
      end
      rem = rem - frames;
      chunks++;
    end while (rem != 0 && chunks < MAX_CHUNKS);
    // expiry pops from the head
    len  = ring_length();
    done = 1'b0;
    while (ring_live > 0 && !done) begin
      expiry = {1'b0, birth_mem[ring_head]} + {1'b0, model_cfg.slot_lifetime};
      if (expiry > {1'b0, em_time}) begin
        done = 1'b1;
      end else begin
        ring_head = next_slot(ring_head, len);
        ring_live = ring_live - 7'd1;
        popped++;
      end
    end
    st.live_count      = ring_live;
    st.head_slot       = ring_head;
    st.tail_slot       = ring_tail;
    st.births          = births[BIRTHS_W-1:0];
    st.expired         = popped[EXP_W-1:0];
    st.chunk_limit_hit = (rem != 0);
    st.current_time    = em_time;
    return st;
  endfunction

  function automatic void note_mismatch(input string what, input logic [63:0] got,
                                        input logic [63:0] want);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
  endfunction

  function automatic void compare_status(input out_item_t got, input out_item_t want);
    if (got.live_count !== want.live_count)
      note_mismatch("live_count", 64'(got.live_count), 64'(want.live_count));
    if (got.head_slot !== want.head_slot)
      note_mismatch("head_slot", 64'(got.head_slot), 64'(want.head_slot));
    if (got.tail_slot !== want.tail_slot)
      note_mismatch("tail_slot", 64'(got.tail_slot), 64'(want.tail_slot));
    if (got.births !== want.births)
      note_mismatch("births", 64'(got.births), 64'(want.births));
    if (got.expired !== want.expired)
      note_mismatch("expired", 64'(got.expired), 64'(want.expired));
    if (got.chunk_limit_hit !== want.chunk_limit_hit)
      note_mismatch("chunk_limit_hit", 64'(got.chunk_limit_hit),
                    64'(want.chunk_limit_hit));
    if (got.current_time !== want.current_time)
      note_mismatch("current_time", 64'(got.current_time), 64'(want.current_time));
  endfunction

  // driver: payload held while stalled, predictor runs on each transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) ring_status_q.push_back(predict_tick(in_data));
      if (!in_valid || !in_stall) begin
        if (tick_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct &&
            !(tick_q[0].wait_drain && ring_status_q.size() != 0)) begin
          tx_next = tick_q.pop_front();
          in_valid <= 1'b1;
          in_data  <= tx_next.item;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_asked) begin
      hold_taken <= hold_taken + 1;
      hold_left  <= 300;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (ring_status_q.size() == 0)
        note_mismatch("status with nothing pending", 64'(out_data.current_time), 64'(0));
      else
        compare_status(out_data, ring_status_q.pop_front());
    end
  end

  task automatic drain_wait();
    while (tick_q.size() != 0 || in_valid || ring_status_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BURST_SIZE:      model_cfg.burst_size      = val[6:0];
      CFG_SLOTS_IN_USE:    model_cfg.slots_in_use    = val[6:0];
      CFG_EMIT_DELAY:      model_cfg.emit_delay      = val[STEP_W-1:0];
      CFG_ACTIVE_DURATION: model_cfg.active_duration = val;
      CFG_SLOT_LIFETIME:   model_cfg.slot_lifetime   = val;
      CFG_REVERSE_ORDER:   model_cfg.reverse_order   = val[0];
      default: ;
    endcase
  endtask

  task automatic write_setup(input logic [31:0] burst, input logic [31:0] slots,
                             input logic [31:0] delay, input logic [31:0] active,
                             input logic [31:0] life, input logic rev);
    drain_wait();
    write_reg(CFG_BURST_SIZE, burst);
    write_reg(CFG_SLOTS_IN_USE, slots);
    write_reg(CFG_EMIT_DELAY, delay);
    write_reg(CFG_ACTIVE_DURATION, active);
    write_reg(CFG_SLOT_LIFETIME, life);
    write_reg(CFG_REVERSE_ORDER, {31'd0, rev});
  endtask

  task automatic queue_tick(input bit restart, input logic [15:0] step,
                            input bit wait_drain);
    tick_req_t r;
    r.item.mode       = restart;
    r.item.frame_step = step;
    r.wait_drain      = wait_drain;
    tick_q.push_back(r);
  endtask

  function automatic logic [15:0] pick_step();
    int d;
    int r;
    int m;
    d = int'(model_cfg.emit_delay);
    r = $urandom_range(0, 99);
    m = d * $urandom_range(1, 17);
    if (r < 30) return 16'($urandom_range(0, 255));
    if (r < 60) return (4 * d + 1 > 65535) ? 16'($urandom_range(0, 65535)) :
                                             16'($urandom_range(0, 4 * d + 1));
    if (r < 85) return 16'($urandom_range(0, 65535));
    return (m > 65535) ? 16'hFFFF : 16'(m);
  endfunction

  task automatic random_setup();
    logic [31:0] burst;
    logic [31:0] slots;
    logic [31:0] delay;
    logic [31:0] active;
    logic [31:0] life;
    burst = ($urandom_range(0, 99) < 8)  ? $urandom_range(9, 127) : $urandom_range(0, 8);
    slots = ($urandom_range(0, 99) < 10) ? $urandom_range(0, 127) : $urandom_range(1, 64);
    case ($urandom_range(0, 3))
      0:       delay = $urandom_range(0, 3);
      1:       delay = $urandom_range(4, 64);
      2:       delay = $urandom_range(200, 1200);
      default: delay = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 3))
      1:       active = $urandom_range(1, 100000);
      2:       active = $urandom;
      default: active = 0;
    endcase
    case ($urandom_range(0, 3))
      0:       life = $urandom_range(0, 4);
      1:       life = $urandom_range(5, 20000);
      2:       life = $urandom;
      default: life = $urandom_range(500, 3000);
    endcase
    write_setup(burst, slots, delay, active, life, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int p;
    int i;
    model_cfg.burst_size      = 7'd1;
    model_cfg.slots_in_use    = 7'd64;
    model_cfg.emit_delay      = 16'd256;
    model_cfg.active_duration = '0;
    model_cfg.slot_lifetime   = 32'd7680;
    model_cfg.reverse_order   = 1'b0;
    em_time   = '0;
    next_emit = '0;
    ring_head = '0;
    ring_tail = '0;
    ring_live = '0;
    tx_idle_pct = 20;
    rx_idle_pct = 66;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings; the store is only defined once a restart has cleared it
    queue_tick(1'b1, 16'h0000, 1'b0);
    queue_tick(1'b0, 16'h0000, 1'b0);
    queue_tick(1'b0, 16'h0001, 1'b0);
    queue_tick(1'b0, 16'hFFFF, 1'b0);   // runs into the chunk limit
    queue_tick(1'b0, 16'd4096, 1'b0);   // exactly the chunk limit
    queue_tick(1'b0, 16'd4097, 1'b0);
    queue_tick(1'b0, 16'h8000, 1'b0);
    queue_tick(1'b1, 16'h7FFF, 1'b0);
    queue_tick(1'b0, 16'h5555, 1'b0);
    queue_tick(1'b0, 16'hAAAA, 1'b0);

    // oversized burst, zero ring length, zero delay, zero lifetime, reverse
    write_setup(32'd127, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1);
    queue_tick(1'b1, 16'h0000, 1'b0);
    queue_tick(1'b0, 16'hFFFF, 1'b0);
    queue_tick(1'b0, 16'h0000, 1'b0);
    queue_tick(1'b0, 16'h0005, 1'b0);
    queue_tick(1'b1, 16'hFFFF, 1'b0);

    // upper extremes: full burst, ring length above the store, longest times
    write_setup(32'd64, 32'd127, 32'd65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_tick(1'b1, 16'h0000, 1'b0);
    queue_tick(1'b0, 16'hFFFF, 1'b0);
    queue_tick(1'b0, 16'h0001, 1'b0);
    queue_tick(1'b0, 16'h0000, 1'b0);
    queue_tick(1'b0, 16'hFFFF, 1'b0);

    // shrink the ring under a full count, no restart
    write_setup(32'd3, 32'd5, 32'd1, 32'd0, 32'd300, 1'b1);
    queue_tick(1'b0, 16'h0000, 1'b0);
    queue_tick(1'b0, 16'h0002, 1'b0);
    queue_tick(1'b0, 16'hFFFF, 1'b0);
    queue_tick(1'b0, 16'h0007, 1'b0);
    queue_tick(1'b0, 16'd300, 1'b0);

    for (p = 1; p < 15; p++) begin
      random_setup();
      if (p >= 10) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (p >= 5) begin
        tx_idle_pct = 66;
        rx_idle_pct = 20;
      end
      // long output hold-off while the driver keeps offering transfers
      if (p == 3 || p == 8) hold_asked = hold_asked + 1;
      for (i = 0; i < 117; i++)
        queue_tick($urandom_range(0, 99) < 4, pick_step(), (i % 40) == 39);
    end

    drain_wait();
    repeat (200) @(posedge clk);
    if (ring_status_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Timed out waiting for the scheduler");
    $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire
